// File: rtl/assert_macros.svh
// Assertion macros shared by the timer queue RTL.
// Expects a clock clk_i and an active-low reset rst_ni in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_PROP(lbl, !(cond), msg)

`endif

// File: rtl/dlq_pkg.sv
// Types and constants of the deadline timer queue.
// Used by dlq_cell, deadline_timer_queue_unit, timer_queue_checker and tb; depends on nothing else.
package dlq_pkg;

  localparam int unsigned TimeW     = 63;
  localparam int unsigned PeriodW   = 32;
  localparam int unsigned MinDelayW = 20;
  localparam int unsigned OutIdW    = 4;
  // Wide enough for any slot id up to the largest supported depth.
  localparam int unsigned MaxIdW    = 6;
  localparam int unsigned MaxRes    = 16;
  localparam int unsigned ResCntW   = $clog2(MaxRes + 1);
  localparam int unsigned ResIdxW   = $clog2(MaxRes);

  localparam logic [MinDelayW-1:0] MinDelayReset = MinDelayW'(100);

  localparam logic CmdAdd  = 1'b0;
  localparam logic CmdTick = 1'b1;

  typedef enum logic [1:0] {
    StAdded   = 2'd0,
    StExpired = 2'd1,
    StNone    = 2'd2,
    StFull    = 2'd3
  } dlq_status_e;

  typedef struct packed {
    logic               cmd;
    logic [TimeW-1:0]   now;
    logic [TimeW-1:0]   deadline;
    logic [PeriodW-1:0] period;
  } dlq_item_t;

  typedef struct packed {
    dlq_status_e        status;
    logic [OutIdW-1:0]  timer_id;
    logic               earliest_changed;
    logic               next_valid;
    logic [TimeW-1:0]   next_delay;
    logic               last;
  } dlq_result_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic               wr_en;
    logic               pick_en;
    logic               clr_pick;
    logic [MaxIdW-1:0]  idx;
    logic [TimeW-1:0]   now;
    logic [TimeW-1:0]   deadline;
    logic [PeriodW-1:0] period;
  } dlq_cmd_t;

  // Running search results handed from cell to cell.
  typedef struct packed {
    logic              sel_vld;
    logic [TimeW-1:0]  sel_dl;
    logic [MaxIdW-1:0] sel_id;
    logic              min_vld;
    logic [TimeW-1:0]  min_dl;
    logic              free_vld;
    logic [MaxIdW-1:0] free_id;
  } dlq_acc_t;

endpackage

// File: rtl/deadline_timer_queue_unit.sv
// Deadline timer queue: top level with the command sequencer and the APB register.
// Depends on dlq_pkg, dlq_cell and assert_macros.svh.
//
// Timers sit in a row of DEPTH slot cells, and every search (lowest free slot, earliest
// deadline, next due timer) runs as one pass along that row, one cell per clock. An add,
// and a tick that expires nothing, show a single word. A tick that expires n timers
// (1 to 16) makes n+1 passes and then shows its words on consecutive cycles. Result
// words carry a one-cycle strobe and must be taken as they come; busy is low again in
// the cycle that shows the last word of an item, so the next command may be issued then.
module deadline_timer_queue_unit import dlq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  dlq_item_t   item_i,
  output logic        result_valid_o,
  output dlq_result_t result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:2]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "assert_macros.svh"

  localparam int unsigned IdW  = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 2);
  localparam logic [CntW-1:0] PassEnd = CntW'(DEPTH + 1);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SPass = 2'd1;
  localparam logic [1:0] SFin  = 2'd2;
  localparam logic [1:0] SEmit = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [ResCntW-1:0]   n_q, n_d;
  logic [ResIdxW-1:0]   k_q, k_d;
  logic                 cmd_q;
  logic [TimeW-1:0]     now_q, dl_q;
  logic [PeriodW-1:0]   per_q;
  dlq_status_e          st_q, st_d;
  logic [IdW-1:0]       rid_q, rid_d;
  logic                 ec_q, ec_d;
  logic                 fin_vld_q, fin_vld_d;
  logic [TimeW-1:0]     fin_dl_q, fin_dl_d;
  logic                 nv_q;
  logic [TimeW-1:0]     nd_q;
  logic [IdW-1:0]       ids_q [MaxRes];
  logic                 id_wr;
  logic [MinDelayW-1:0] min_delay_q;
  dlq_result_t          res_q, res_d;
  logic                 res_vld_q, res_vld_d;
  logic                 accept;
  logic                 cfg_wr;
  dlq_cmd_t             cell_cmd;
  dlq_acc_t             acc [DEPTH];
  dlq_acc_t             chain_end;
  logic                 cur_lt;
  logic [TimeW:0]       diff;
  logic [TimeW-1:0]     nd_calc;
  logic                 emit_last;

  assign accept    = start && !busy;
  assign busy      = (state_q != SIdle);
  assign chain_end = acc[DEPTH-1];

  // Slot row.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dlq_acc_t acc_in;
    if (i == 0) begin : g_head
      assign acc_in = '0;
    end else begin : g_link
      assign acc_in = acc[i-1];
    end
    dlq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cell_id_i (MaxIdW'(i)),
      .cmd_i     (cell_cmd),
      .acc_i     (acc_in),
      .acc_o     (acc[i])
    );
  end

  // Configuration register.
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(min_delay_q) : '0;

  // Delay until the earliest remaining deadline, floored at min_delay.
  assign diff = {1'b0, fin_dl_q} - {1'b0, now_q};
  always_comb begin
    if (!fin_vld_q) begin
      nd_calc = '0;
    end else if (!diff[TimeW] && (diff[TimeW-1:0] > TimeW'(min_delay_q))) begin
      nd_calc = diff[TimeW-1:0];
    end else begin
      nd_calc = TimeW'(min_delay_q);
    end
  end

  assign cur_lt    = dl_q < chain_end.min_dl;
  assign emit_last = ({1'b0, k_q} == (n_q - ResCntW'(1)));

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    k_d       = k_q;
    st_d      = st_q;
    rid_d     = rid_q;
    ec_d      = ec_q;
    fin_vld_d = fin_vld_q;
    fin_dl_d  = fin_dl_q;
    id_wr     = 1'b0;
    res_vld_d = 1'b0;
    res_d     = res_q;

    cell_cmd          = '0;
    cell_cmd.now      = now_q;
    cell_cmd.deadline = dl_q;
    cell_cmd.period   = per_q;
    cell_cmd.clr_pick = accept && (item_i.cmd == CmdTick);

    unique case (state_q)
      SIdle: begin
        if (accept) begin
          state_d = SPass;
          cnt_d   = '0;
          n_d     = '0;
        end
      end
      SPass: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == PassEnd) begin
          cnt_d = '0;
          if (cmd_q == CmdAdd) begin
            state_d = SFin;
            if (!chain_end.free_vld) begin
              st_d      = StFull;
              rid_d     = '0;
              ec_d      = 1'b0;
              fin_vld_d = chain_end.min_vld;
              fin_dl_d  = chain_end.min_dl;
            end else begin
              cell_cmd.wr_en = 1'b1;
              cell_cmd.idx   = chain_end.free_id;
              st_d           = StAdded;
              rid_d          = chain_end.free_id[IdW-1:0];
              ec_d           = !chain_end.min_vld || cur_lt;
              fin_vld_d      = 1'b1;
              fin_dl_d       = (!chain_end.min_vld || cur_lt) ? dl_q : chain_end.min_dl;
            end
          end else if (chain_end.sel_vld && (n_q < ResCntW'(MaxRes))) begin
            // Expire this timer and search again for the next one.
            cell_cmd.pick_en = 1'b1;
            cell_cmd.idx     = chain_end.sel_id;
            id_wr            = 1'b1;
            n_d              = n_q + ResCntW'(1);
          end else begin
            state_d   = SFin;
            st_d      = StNone;
            rid_d     = '0;
            ec_d      = 1'b0;
            fin_vld_d = chain_end.min_vld;
            fin_dl_d  = chain_end.min_dl;
          end
        end
      end
      SFin: begin
        if ((cmd_q == CmdAdd) || (n_q == '0)) begin
          state_d                = SIdle;
          res_vld_d              = 1'b1;
          res_d.status           = st_q;
          res_d.timer_id         = OutIdW'(rid_q);
          res_d.earliest_changed = ec_q;
          res_d.next_valid       = fin_vld_q;
          res_d.next_delay       = nd_calc;
          res_d.last             = 1'b1;
        end else begin
          state_d = SEmit;
          k_d     = '0;
        end
      end
      SEmit: begin
        res_vld_d              = 1'b1;
        res_d.status           = StExpired;
        res_d.timer_id         = OutIdW'(ids_q[k_q]);
        res_d.earliest_changed = 1'b0;
        res_d.next_valid       = nv_q;
        res_d.next_delay       = nd_q;
        res_d.last             = emit_last;
        k_d                    = k_q + ResIdxW'(1);
        if (emit_last) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cnt_q       <= '0;
      n_q         <= '0;
      k_q         <= '0;
      res_vld_q   <= 1'b0;
      min_delay_q <= MinDelayReset;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      n_q       <= n_d;
      k_q       <= k_d;
      res_vld_q <= res_vld_d;
      if (cfg_wr) begin
        min_delay_q <= pwdata[MinDelayW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= item_i.cmd;
      now_q <= item_i.now;
      dl_q  <= item_i.deadline;
      per_q <= item_i.period;
    end
    st_q      <= st_d;
    rid_q     <= rid_d;
    ec_q      <= ec_d;
    fin_vld_q <= fin_vld_d;
    fin_dl_q  <= fin_dl_d;
    res_q     <= res_d;
    if (id_wr) begin
      ids_q[n_q[ResIdxW-1:0]] <= chain_end.sel_id[IdW-1:0];
    end
    if (state_q == SFin) begin
      nv_q <= fin_vld_q;
      nd_q <= nd_calc;
    end
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  // The words of one tick leave on consecutive cycles.
  `ASSERT_PROP(a_burst_contiguous, (res_vld_q && !res_q.last) |=> res_vld_q,
               "tick result burst broken before its last word")
  // More words of an item are still to come only while the block is busy.
  `ASSERT_PROP(a_busy_in_burst, (res_vld_q && !res_q.last) |-> busy,
               "block idle while a result burst is unfinished")
  `ASSERT_NEVER(a_res_count, n_q > ResCntW'(MaxRes),
                "more expired timers recorded than one tick may report")

endmodule

// File: rtl/dlq_cell.sv
// One timer slot of the queue and its stage of the search chain.
// Depends on dlq_pkg.
module dlq_cell import dlq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [MaxIdW-1:0] cell_id_i,
  input  dlq_cmd_t          cmd_i,
  input  dlq_acc_t          acc_i,
  output dlq_acc_t          acc_o
);

  logic               busy_q, busy_d;
  logic               picked_q, picked_d;
  logic               due_q;
  logic [TimeW-1:0]   deadline_q, deadline_d;
  logic [PeriodW-1:0] period_q, period_d;
  dlq_acc_t           acc_q, acc_d;
  logic               hit;
  logic [TimeW:0]     rearm_sum;
  logic [TimeW-1:0]   rearm_dl;

  assign hit       = (cmd_i.idx == cell_id_i);
  assign rearm_sum = {1'b0, cmd_i.now} + (TimeW + 1)'(period_q);
  // The rearmed deadline saturates at the largest time value.
  assign rearm_dl  = rearm_sum[TimeW] ? '1 : rearm_sum[TimeW-1:0];

  always_comb begin
    busy_d     = busy_q;
    picked_d   = picked_q;
    deadline_d = deadline_q;
    period_d   = period_q;
    if (cmd_i.clr_pick) begin
      picked_d = 1'b0;
    end
    if (cmd_i.wr_en && hit) begin
      busy_d     = 1'b1;
      deadline_d = cmd_i.deadline;
      period_d   = cmd_i.period;
    end
    if (cmd_i.pick_en && hit) begin
      picked_d = 1'b1;
      if (period_q != '0) begin
        deadline_d = rearm_dl;
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  // Each lane keeps the incoming word unless this slot beats it; a strict compare
  // lets the lower slot id win a tie, since ids rise along the chain.
  always_comb begin
    acc_d = acc_i;
    if (due_q && (!acc_i.sel_vld || deadline_q < acc_i.sel_dl)) begin
      acc_d.sel_vld = 1'b1;
      acc_d.sel_dl  = deadline_q;
      acc_d.sel_id  = cell_id_i;
    end
    if (busy_q && (!acc_i.min_vld || deadline_q < acc_i.min_dl)) begin
      acc_d.min_vld = 1'b1;
      acc_d.min_dl  = deadline_q;
    end
    if (!busy_q && !acc_i.free_vld) begin
      acc_d.free_vld = 1'b1;
      acc_d.free_id  = cell_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      picked_q <= 1'b0;
      due_q    <= 1'b0;
      acc_q    <= '0;
    end else begin
      busy_q   <= busy_d;
      picked_q <= picked_d;
      due_q    <= busy_q && !picked_q && (deadline_q <= cmd_i.now);
      acc_q    <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    deadline_q <= deadline_d;
    period_q   <= period_d;
  end

  assign acc_o = acc_q;

endmodule

// File: sim/timer_queue_checker.sv
// Checker for the deadline timer queue: follows commands, result words and register
// accesses, predicts every result word and compares it field by field.
// Depends on dlq_pkg only.
module timer_queue_checker import dlq_pkg::*; #(
  parameter int unsigned DEPTH        = 16,
  parameter logic [2:2]  MinDelayAddr = 1'b0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  dlq_item_t   item_i,
  input  logic        result_valid_i,
  input  dlq_result_t result_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:2]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic [31:0] prdata_i,
  input  logic        pready_i,
  output int unsigned outstanding_o,
  output int unsigned errors_o
);

  localparam logic [TimeW-1:0] TimeMax    = '1;
  localparam int unsigned      MaxReports = 10;

  logic [TimeW-1:0]     slot_dl  [DEPTH];
  logic [PeriodW-1:0]   slot_per [DEPTH];
  logic [DEPTH-1:0]     slot_used;
  logic [MinDelayW-1:0] min_delay;
  dlq_result_t          due_words[$];
  int unsigned          errors;

  task automatic flag(input string msg);
    errors++;
    if (errors <= MaxReports) $display("%0t: %s", $time, msg);
  endtask

  // Earliest armed deadline and the wakeup delay that goes with it.
  task automatic next_wakeup(input logic [TimeW-1:0] now, output logic vld,
                             output logic [TimeW-1:0] delay);
    logic [TimeW-1:0] best;
    best = '0;
    vld  = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_used[i] && (!vld || slot_dl[i] < best)) begin
        best = slot_dl[i];
        vld  = 1'b1;
      end
    end
    if (!vld) delay = '0;
    else if (best > now && best - now > TimeW'(min_delay)) delay = best - now;
    else delay = TimeW'(min_delay);
  endtask

  task automatic predict_command(input dlq_item_t cmd);
    dlq_result_t      word;
    int               slot;
    int               best;
    int               order[$];
    logic [DEPTH-1:0] picked;
    logic             becomes_first;
    logic             vld;
    logic [TimeW-1:0] delay;
    logic [TimeW:0]   rearm;
    word = '0;
    if (cmd.cmd == CmdAdd) begin
      slot = -1;
      for (int i = DEPTH - 1; i >= 0; i--) begin
        if (!slot_used[i]) slot = i;
      end
      if (slot < 0) begin
        word.status = StFull;
      end else begin
        // The new timer leads only if no armed deadline is at or before its own.
        becomes_first = 1'b1;
        for (int i = 0; i < DEPTH; i++) begin
          if (slot_used[i] && slot_dl[i] <= cmd.deadline) becomes_first = 1'b0;
        end
        slot_used[slot]       = 1'b1;
        slot_dl[slot]         = cmd.deadline;
        slot_per[slot]        = cmd.period;
        word.status           = StAdded;
        word.timer_id         = OutIdW'(slot);
        word.earliest_changed = becomes_first;
      end
      next_wakeup(cmd.now, vld, delay);
      word.next_valid = vld;
      word.next_delay = delay;
      word.last       = 1'b1;
      due_words.push_back(word);
    end else begin
      // Due timers in deadline order; the ascending scan gives ties to the lower id.
      picked = '0;
      do begin
        best = -1;
        for (int i = 0; i < DEPTH; i++) begin
          if (slot_used[i] && !picked[i] && slot_dl[i] <= cmd.now &&
              (best < 0 || slot_dl[i] < slot_dl[best])) best = i;
        end
        if (best >= 0) begin
          picked[best] = 1'b1;
          order.push_back(best);
        end
      end while (best >= 0 && order.size() < MaxRes);
      foreach (order[k]) begin
        if (slot_per[order[k]] != '0) begin
          rearm = cmd.now + slot_per[order[k]];
          slot_dl[order[k]] = rearm[TimeW] ? TimeMax : rearm[TimeW-1:0];
        end else begin
          slot_used[order[k]] = 1'b0;
        end
      end
      next_wakeup(cmd.now, vld, delay);
      word.next_valid = vld;
      word.next_delay = delay;
      if (order.size() == 0) begin
        word.status = StNone;
        word.last   = 1'b1;
        due_words.push_back(word);
      end else begin
        foreach (order[k]) begin
          word.status   = StExpired;
          word.timer_id = OutIdW'(order[k]);
          word.last     = (k == order.size() - 1);
          due_words.push_back(word);
        end
      end
    end
  endtask

  task automatic check_word(input dlq_result_t got);
    dlq_result_t want;
    if (due_words.size() == 0) begin
      flag($sformatf("result word with none expected: %p", got));
    end else begin
      want = due_words.pop_front();
      if (got.status != want.status)
        flag($sformatf("status: expected %0d, got %0d", want.status, got.status));
      if (got.timer_id != want.timer_id)
        flag($sformatf("timer_id: expected %0d, got %0d", want.timer_id, got.timer_id));
      if (got.earliest_changed != want.earliest_changed)
        flag($sformatf("earliest_changed: expected %0b, got %0b",
                       want.earliest_changed, got.earliest_changed));
      if (got.next_valid != want.next_valid)
        flag($sformatf("next_valid: expected %0b, got %0b", want.next_valid, got.next_valid));
      if (got.next_delay != want.next_delay)
        flag($sformatf("next_delay: expected %0h, got %0h", want.next_delay, got.next_delay));
      if (got.last != want.last)
        flag($sformatf("last: expected %0b, got %0b", want.last, got.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_used = '0;
      min_delay = MinDelayReset;
      errors    = 0;
      due_words.delete();
      outstanding_o <= 0;
      errors_o      <= 0;
    end else begin
      if (result_valid_i) check_word(result_i);
      if (start_i && !busy_i) predict_command(item_i);
      if (psel_i && penable_i && pready_i && paddr_i == MinDelayAddr) begin
        if (pwrite_i) begin
          min_delay = pwdata_i[MinDelayW-1:0];
        end else if (prdata_i[MinDelayW-1:0] != min_delay) begin
          flag($sformatf("min_delay read: expected %0d, got %0d",
                         min_delay, prdata_i[MinDelayW-1:0]));
        end
      end
      outstanding_o <= due_words.size();
      errors_o      <= errors;
    end
  end

endmodule

// File: sim/tb.sv
// Top of the deadline timer queue testbench: clock, reset, commands and register writes.
// Depends on dlq_pkg, deadline_timer_queue_unit and timer_queue_checker.
module tb;
  import dlq_pkg::*;

  localparam int unsigned      DEPTH        = 16;
  localparam logic [2:2]       MinDelayAddr = 1'b0;
  localparam int unsigned      Limit        = 600000;
  localparam int unsigned      DrainCycles  = 350;
  localparam int unsigned      Chunks       = 7;
  localparam int unsigned      ChunkLen     = 40;
  localparam logic [TimeW-1:0] TimeMax      = '1;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start;
  logic        busy;
  dlq_item_t   item;
  logic        result_valid;
  dlq_result_t result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:2]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int unsigned outstanding;
  int unsigned errors;
  int unsigned cycles = 0;
  logic [TimeW-1:0] wall_us;

  always #1 clk_i = ~clk_i;

  deadline_timer_queue_unit #(.DEPTH(DEPTH)) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item),
    .result_valid_o (result_valid),
    .result_o       (result),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  timer_queue_checker #(.DEPTH(DEPTH), .MinDelayAddr(MinDelayAddr)) u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .item_i         (item),
    .result_valid_i (result_valid),
    .result_i       (result),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_i       (prdata),
    .pready_i       (pready),
    .outstanding_o  (outstanding),
    .errors_o       (errors)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == Limit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [TimeW-1:0] any_time();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[TimeW-1:0];
  endfunction

  function automatic dlq_item_t make_cmd(input logic op, input logic [TimeW-1:0] now,
                                         input logic [TimeW-1:0] deadline,
                                         input logic [PeriodW-1:0] period);
    dlq_item_t cmd;
    cmd.cmd      = op;
    cmd.now      = now;
    cmd.deadline = deadline;
    cmd.period   = period;
    return cmd;
  endfunction

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) < 3) ? $urandom_range(1, 11) : 0;
  endfunction

  // Mostly adds due shortly after the running time base and ticks that move it on,
  // with a little noise of fully random words.
  function automatic dlq_item_t next_command(input int unsigned add_pct);
    dlq_item_t   cmd;
    int unsigned pick;
    cmd  = make_cmd(CmdTick, wall_us, any_time(), $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      cmd.cmd = $urandom_range(0, 1) ? CmdTick : CmdAdd;
      cmd.now = any_time();
      // Follow a forward jump, but stay well clear of the saturation point.
      if (cmd.now > wall_us && cmd.now < (TimeMax >> 1)) wall_us = cmd.now;
    end else if (pick < 8 + add_pct) begin
      cmd.cmd      = CmdAdd;
      cmd.deadline = wall_us + $urandom_range(0, 3000);
      if ($urandom_range(0, 9) == 0) cmd.deadline = (wall_us > 600) ? wall_us - 600 : '0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: cmd.period = '0;
        9:          cmd.period = $urandom;
        default:    cmd.period = $urandom_range(1, 2000);
      endcase
    end else begin
      wall_us = wall_us + $urandom_range(0, 1200);
      cmd.now = wall_us;
    end
    return cmd;
  endfunction

  task automatic issue(input dlq_item_t cmd, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    item  <= cmd;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0 || busy);
  endtask

  // Write min_delay, then read it back so the checker can compare.
  task automatic write_min_delay(input logic [MinDelayW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MinDelayAddr;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [MinDelayW-1:0] settings [Chunks];
    settings = '{20'd0, 20'd1000000, MinDelayW'($urandom_range(0, 5000)), 20'd100,
                 20'hFFFFF, MinDelayW'($urandom_range(0, 300)), 20'd1};
    start   <= 1'b0;
    item    <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MinDelayAddr;
    pwdata  <= '0;
    wall_us  = TimeW'(5000);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, with min_delay at its reset value.
    issue(make_cmd(CmdTick, '0, '0, '0), 0);
    issue(make_cmd(CmdAdd, '0, 1000, 0), gap_len());
    issue(make_cmd(CmdAdd, '0, 500, 300), gap_len());
    issue(make_cmd(CmdAdd, '0, 1000, 0), gap_len());
    issue(make_cmd(CmdAdd, '0, TimeMax, '1), gap_len());
    // The earliest deadline is exactly min_delay ahead.
    issue(make_cmd(CmdTick, 400, TimeMax, '1), gap_len());
    issue(make_cmd(CmdTick, 1000, '0, '0), gap_len());
    // A deadline that has already passed.
    issue(make_cmd(CmdAdd, 2000, '0, 0), gap_len());
    // Every rearm here saturates.
    issue(make_cmd(CmdTick, TimeMax, '0, '0), gap_len());
    for (int i = 0; i < 14; i++) begin
      issue(make_cmd(CmdAdd, TimeW'(i), TimeW'((i % 5) * 100), 0), gap_len());
    end
    issue(make_cmd(CmdAdd, 50, 7, 9), gap_len());
    issue(make_cmd(CmdTick, TimeMax, '0, '0), gap_len());
    drain();

    for (int c = 0; c < Chunks; c++) begin
      write_min_delay(settings[c]);
      for (int n = 0; n < ChunkLen; n++) begin
        issue(next_command((c % 2) ? 40 : 70), (c == Chunks - 1) ? 0 : gap_len());
      end
      drain();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
